// ===== hdl/look_at_view_matrix_assert.svh =====
// Assertion macros used by lav_ser.
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LAV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define LAV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/lav_pkg.sv =====
`timescale 1ns / 1ps

package lav_pkg;

    localparam int FRAC_BITS  = 16;
    // width of a vector going into the normalizer
    localparam int NW         = 35;
    // width of a unit vector component
    localparam int FW         = FRAC_BITS + 2;
    // wide accumulator width for cross and dot products
    localparam int RW         = 66;
    localparam int SQ_STAGES  = 32;
    localparam int DIV_STAGES = FRAC_BITS + 1;
    // width of the rounded dividend
    localparam int NB         = 31 + FRAC_BITS;
    // squared length at or below which a vector counts as zero
    localparam logic [63:0] THRESH_SQ = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;
    localparam logic [31:0] ONE_FIX   = 32'd1 << FRAC_BITS;

    typedef logic [2:0][31:0] vec32_t;

    // data riding alongside the arithmetic
    typedef struct packed {
        vec32_t eye;
        vec32_t va;
        vec32_t vb;
    } side_t;

    // drop FRAC_BITS fraction bits, round to nearest, ties away from zero
    function automatic logic signed [RW-1:0] round_frac(input logic signed [RW-1:0] v);
        logic [RW-1:0] mag;
        logic [RW-1:0] m;
        mag = v[RW-1] ? (~v + 1'b1) : v;
        m = (mag + (RW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        round_frac = v[RW-1] ? $signed(~m + 1'b1) : $signed(m);
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [RW-1:0] v);
        if ((&v[RW-1:31]) || !(|v[RW-1:31])) begin
            sat32 = v[31:0];
        end else if (v[RW-1]) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = 32'h7fff_ffff;
        end
    endfunction

endpackage

// ===== hdl/lav_norm.sv =====
`timescale 1ns / 1ps

module lav_norm import lav_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [2:0][NW-1:0]   in_vec,
    input  side_t                in_side,
    output logic                 out_valid,
    output logic [2:0][FW-1:0]   out_vec,
    output side_t                out_side
);

    typedef struct packed {
        logic             zero;
        logic [2:0]       neg;
        logic [2:0][29:0] ms;
        side_t            side;
    } nctl_t;

    typedef struct packed {
        logic [30:0]          rem;
        logic [FRAC_BITS:0]   nlo;
        logic [FRAC_BITS:0]   q;
    } dlane_t;

    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [2:0]         neg1_reg, neg2_reg, neg3_reg;
    logic [2:0][NW-1:0] mag1_reg, mag2_reg, mag3_reg;
    logic [2:0][NW-1:0] mag1_next;
    side_t              side1_reg, side2_reg, side3_reg;
    logic [NW-1:0]      mx2_reg;
    logic [NW-1:0]      mx2_next;
    logic               small2_reg;
    logic [2:0][61:0]   sq2_reg;
    logic               zero3_reg;
    logic [5:0]         blen3_reg;
    logic [5:0]         blen3_next;
    logic [63:0]        sum3;
    nctl_t              c4_reg, c5_reg;
    nctl_t              c4_next;
    logic [2:0][59:0]   sq5_reg;

    logic [62:0]        sqx_reg [SQ_STAGES+1];
    logic [62:0]        sqr_reg [SQ_STAGES+1];
    nctl_t              sqc_reg [SQ_STAGES+1];
    logic [SQ_STAGES:0] sqv_reg;

    dlane_t [2:0]       dv_reg  [DIV_STAGES+1];
    logic [30:0]        dd_reg  [DIV_STAGES+1];
    nctl_t              dc_reg  [DIV_STAGES+1];
    logic [DIV_STAGES:0] dvv_reg;

    logic [30:0]        len;
    logic               out_v_reg;
    logic [2:0][FW-1:0] out_vec_reg;
    side_t              out_side_reg;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            sqv_reg   <= '0;
            dvv_reg   <= '0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            sqv_reg   <= {sqv_reg[SQ_STAGES-1:0], v5_reg};
            dvv_reg   <= {dvv_reg[DIV_STAGES-1:0], sqv_reg[SQ_STAGES]};
            out_v_reg <= dvv_reg[DIV_STAGES];
        end
    end

    // stage 1: magnitudes and signs
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag1_next[i] = in_vec[i][NW-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
        end
    end

    // stage 2: largest magnitude, exact squares
    always_comb begin
        mx2_next = mag1_reg[0];
        if (mag1_reg[1] > mx2_next) begin
            mx2_next = mag1_reg[1];
        end
        if (mag1_reg[2] > mx2_next) begin
            mx2_next = mag1_reg[2];
        end
    end

    // stage 3: tiny-vector test and bit length of the largest magnitude
    assign sum3 = 64'(sq2_reg[0]) + 64'(sq2_reg[1]) + 64'(sq2_reg[2]);

    always_comb begin
        blen3_next = '0;
        for (int k = 0; k < NW; k++) begin
            if (mx2_reg[k]) begin
                blen3_next = 6'(k + 1);
            end
        end
    end

    // stage 4: scale so the largest lies in [2^29, 2^30)
    always_comb begin
        logic [5:0]    sh;
        logic [NW-1:0] t;
        sh = (blen3_reg > 6'd30) ? (blen3_reg - 6'd30) : (6'd30 - blen3_reg);
        c4_next.zero = zero3_reg;
        c4_next.neg  = neg3_reg;
        c4_next.side = side3_reg;
        for (int i = 0; i < 3; i++) begin
            t = (blen3_reg > 6'd30) ? (mag3_reg[i] >> sh) : (mag3_reg[i] << sh);
            c4_next.ms[i] = t[29:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                neg1_reg[i] <= in_vec[i][NW-1];
                sq2_reg[i]  <= mag1_reg[i][30:0] * mag1_reg[i][30:0];
                sq5_reg[i]  <= c4_reg.ms[i] * c4_reg.ms[i];
            end
            mag1_reg   <= mag1_next;
            side1_reg  <= in_side;
            mag2_reg   <= mag1_reg;
            neg2_reg   <= neg1_reg;
            side2_reg  <= side1_reg;
            mx2_reg    <= mx2_next;
            small2_reg <= (mx2_next[NW-1:31] == '0);
            zero3_reg  <= small2_reg && (sum3 <= THRESH_SQ);
            blen3_reg  <= blen3_next;
            mag3_reg   <= mag2_reg;
            neg3_reg   <= neg2_reg;
            side3_reg  <= side2_reg;
            c4_reg     <= c4_next;
            c5_reg     <= c4_reg;
            // stage 6: scaled sum of squares enters the root pipeline
            sqx_reg[0] <= 63'(sq5_reg[0]) + 63'(sq5_reg[1]) + 63'(sq5_reg[2]);
            sqr_reg[0] <= '0;
            sqc_reg[0] <= c5_reg;
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
        localparam logic [62:0] BIT = 63'(1) << (62 - 2 * k);
        logic [62:0] trial;
        assign trial = sqr_reg[k] + BIT;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (sqx_reg[k] >= trial) begin
                    sqx_reg[k+1] <= sqx_reg[k] - trial;
                    sqr_reg[k+1] <= (sqr_reg[k] >> 1) + BIT;
                end else begin
                    sqx_reg[k+1] <= sqx_reg[k];
                    sqr_reg[k+1] <= sqr_reg[k] >> 1;
                end
                sqc_reg[k+1] <= sqc_reg[k];
            end
        end
    end

    assign len = sqr_reg[SQ_STAGES][30:0];

    // dividend with half the divisor added for rounding
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                logic [NB-1:0] n;
                n = NB'({sqc_reg[SQ_STAGES].ms[i], {FRAC_BITS{1'b0}}}) + NB'(len[30:1]);
                dv_reg[0][i].rem <= {1'b0, n[NB-1:FRAC_BITS+1]};
                dv_reg[0][i].nlo <= n[FRAC_BITS:0];
                dv_reg[0][i].q   <= '0;
            end
            dd_reg[0] <= len;
            dc_reg[0] <= sqc_reg[SQ_STAGES];
        end
    end

    // restoring divide, one quotient bit per stage, three lanes
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    logic [31:0] r2;
                    logic        ge;
                    r2 = {dv_reg[k][i].rem, dv_reg[k][i].nlo[FRAC_BITS]};
                    ge = (r2 >= {1'b0, dd_reg[k]});
                    dv_reg[k+1][i].rem <= ge ? 31'(r2 - {1'b0, dd_reg[k]}) : r2[30:0];
                    dv_reg[k+1][i].nlo <= dv_reg[k][i].nlo << 1;
                    dv_reg[k+1][i].q   <= {dv_reg[k][i].q[FRAC_BITS-1:0], ge};
                end
                dd_reg[k+1] <= dd_reg[k];
                dc_reg[k+1] <= dc_reg[k];
            end
        end
    end

    // clamp to one, apply sign, force zero for tiny vectors
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                logic [FRAC_BITS:0] qc;
                logic [FW-1:0]      qe;
                qc = (dv_reg[DIV_STAGES][i].q > ((FRAC_BITS+1)'(1) << FRAC_BITS)) ?
                     ((FRAC_BITS+1)'(1) << FRAC_BITS) : dv_reg[DIV_STAGES][i].q;
                qe = {1'b0, qc};
                if (dc_reg[DIV_STAGES].zero) begin
                    out_vec_reg[i] <= '0;
                end else if (dc_reg[DIV_STAGES].neg[i]) begin
                    out_vec_reg[i] <= ~qe + 1'b1;
                end else begin
                    out_vec_reg[i] <= qe;
                end
            end
            out_side_reg <= dc_reg[DIV_STAGES].side;
        end
    end

    assign out_valid = out_v_reg;
    assign out_vec   = out_vec_reg;
    assign out_side  = out_side_reg;

endmodule

// ===== hdl/lav_cross.sv =====
`timescale 1ns / 1ps

module lav_cross import lav_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  vec32_t             a,
    input  vec32_t             b,
    input  side_t              in_side,
    output logic               out_valid,
    output logic [2:0][NW-1:0] out_vec,
    output side_t              out_side
);

    logic                   v1_reg, v2_reg, v3_reg;
    logic signed [63:0]     p_reg [6];
    logic signed [RW-1:0]   d_reg [3];
    logic [2:0][NW-1:0]     r_reg;
    side_t                  side1_reg, side2_reg, side3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // partial products
            p_reg[0] <= $signed(a[1]) * $signed(b[2]);
            p_reg[1] <= $signed(a[2]) * $signed(b[1]);
            p_reg[2] <= $signed(a[2]) * $signed(b[0]);
            p_reg[3] <= $signed(a[0]) * $signed(b[2]);
            p_reg[4] <= $signed(a[0]) * $signed(b[1]);
            p_reg[5] <= $signed(a[1]) * $signed(b[0]);
            side1_reg <= in_side;
            // differences
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= RW'(p_reg[2*i]) - RW'(p_reg[2*i+1]);
            end
            side2_reg <= side1_reg;
            // back to FRAC_BITS fraction bits
            for (int i = 0; i < 3; i++) begin
                r_reg[i] <= NW'(round_frac(d_reg[i]));
            end
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_vec   = r_reg;
    assign out_side  = side3_reg;

endmodule

// ===== hdl/lav_mat.sv =====
`timescale 1ns / 1ps

module lav_mat import lav_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [2:0][NW-1:0] u,
    input  side_t              in_side,
    output logic               out_valid,
    output logic [15:0][31:0]  out_mat
);

    // in_side.va holds forward, in_side.vb holds side
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [RW-1:0] ps_reg [3];
    logic signed [RW-1:0] pu_reg [3];
    logic signed [RW-1:0] pf_reg [3];
    logic signed [RW-1:0] ds_reg, du_reg, df_reg;
    logic signed [RW-1:0] rs_reg, ru_reg, rf_reg;
    logic [2:0][NW-1:0]   u1_reg, u2_reg, u3_reg;
    side_t                side1_reg, side2_reg, side3_reg;
    logic [15:0][31:0]    mat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // products with the eye position; unit components fit in 32 bits
            for (int i = 0; i < 3; i++) begin
                ps_reg[i] <= $signed(in_side.vb[i]) * $signed(in_side.eye[i]);
                pu_reg[i] <= $signed(u[i][31:0]) * $signed(in_side.eye[i]);
                pf_reg[i] <= $signed(in_side.va[i]) * $signed(in_side.eye[i]);
            end
            u1_reg    <= u;
            side1_reg <= in_side;
            // dot sums
            ds_reg    <= ps_reg[0] + ps_reg[1] + ps_reg[2];
            du_reg    <= pu_reg[0] + pu_reg[1] + pu_reg[2];
            df_reg    <= pf_reg[0] + pf_reg[1] + pf_reg[2];
            u2_reg    <= u1_reg;
            side2_reg <= side1_reg;
            // rounding
            rs_reg    <= round_frac(ds_reg);
            ru_reg    <= round_frac(du_reg);
            rf_reg    <= round_frac(df_reg);
            u3_reg    <= u2_reg;
            side3_reg <= side2_reg;
            // assemble and saturate the matrix
            for (int r = 0; r < 3; r++) begin
                mat_reg[r*4+0] <= sat32(RW'($signed(side3_reg.vb[r])));
                mat_reg[r*4+1] <= sat32(RW'($signed(u3_reg[r])));
                mat_reg[r*4+2] <= sat32(-RW'($signed(side3_reg.va[r])));
                mat_reg[r*4+3] <= '0;
            end
            mat_reg[12] <= sat32(-rs_reg);
            mat_reg[13] <= sat32(-ru_reg);
            mat_reg[14] <= sat32(rf_reg);
            mat_reg[15] <= ONE_FIX;
        end
    end

    assign out_valid = v4_reg;
    assign out_mat   = mat_reg;

endmodule

// ===== hdl/lav_ser.sv =====
`timescale 1ns / 1ps
`include "look_at_view_matrix_assert.svh"

module lav_ser import lav_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [15:0][31:0] in_mat,
    output logic              load,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_first_index,
    output logic [1:0]        m_second_index,
    output logic [31:0]       m_entry_value,
    output logic              m_last
);

    logic        busy_reg;
    logic [3:0]  cnt_reg;
    logic [31:0] mat_reg [16];
    logic        fin;

    // last word of the current matrix leaves this cycle
    assign fin  = busy_reg && m_ready && (cnt_reg == 4'd15);
    assign load = in_valid && (!busy_reg || fin);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg && m_ready) begin
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // matrix buffer
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int k = 0; k < 16; k++) begin
                mat_reg[k] <= in_mat[k];
            end
        end
    end

    assign m_valid        = busy_reg;
    assign m_first_index  = cnt_reg[3:2];
    assign m_second_index = cnt_reg[1:0];
    assign m_entry_value  = mat_reg[cnt_reg];
    assign m_last         = (cnt_reg == 4'd15);

    `LAV_ASSERT_NEXT(a_load_starts, load, busy_reg && cnt_reg == 4'd0)
    `LAV_ASSERT_NEXT(a_done_frees, fin && !load, !busy_reg)
    `LAV_ASSERT_NEXT(a_stall_holds, m_valid && !m_ready, m_valid && $stable(cnt_reg))

endmodule

// ===== hdl/look_at_view_matrix.sv =====
`timescale 1ns / 1ps
// Right-handed look-at view matrix, Q16.16 fixed point.
// Input channel (s_valid/s_ready): one word holds eye, target and up vectors.
// Result channel (m_valid/m_ready): sixteen words per input, one matrix entry
// each, row-major from (0,0) to (3,3); m_last marks entry (3,3).
// The pipeline takes a new input every cycle while s_ready is high; the
// sixteen-word result port limits sustained throughput. Each normalizer holds
// a 32-stage root and a FRAC_BITS+1 stage divider.
// When the receiver stalls, the finished matrix waits in the output buffer;
// the pipeline holds once the next matrix reaches its end. Nothing is lost or
// repeated. s_ready drops only while a finished matrix sits at the pipeline end
// with the buffer still busy.
// Reset (aresetn low, synchronous) clears all valid bits and the output
// buffer's busy flag and word count.
module look_at_view_matrix import lav_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_eye_x,
    input  logic signed [31:0] s_eye_y,
    input  logic signed [31:0] s_eye_z,
    input  logic signed [31:0] s_target_x,
    input  logic signed [31:0] s_target_y,
    input  logic signed [31:0] s_target_z,
    input  logic signed [31:0] s_up_x,
    input  logic signed [31:0] s_up_y,
    input  logic signed [31:0] s_up_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_first_index,
    output logic [1:0]         m_second_index,
    output logic signed [31:0] m_entry_value,
    output logic               m_last
);

    logic               en;
    logic               load;
    logic               v0_reg;
    logic [2:0][NW-1:0] d0_reg;
    side_t              side0_reg;

    logic               n1_v, c1_v, n2_v, c2_v, mt_v;
    logic [2:0][FW-1:0] n1_vec, n2_vec;
    side_t              n1_side, c1_side, n2_side, c2_side;
    side_t              c1_in_side, c2_in_side;
    vec32_t             n1_f32, n2_s32;
    logic [2:0][NW-1:0] c1_vec, c2_vec;
    logic [15:0][31:0]  mt_mat;
    logic [31:0]        entry;

    // pipeline moves unless a finished matrix is blocked
    assign en      = !mt_v || load;
    assign s_ready = en;

    // input stage: direction = target - eye
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d0_reg[0]     <= NW'(s_target_x) - NW'(s_eye_x);
            d0_reg[1]     <= NW'(s_target_y) - NW'(s_eye_y);
            d0_reg[2]     <= NW'(s_target_z) - NW'(s_eye_z);
            side0_reg.eye <= {s_eye_z, s_eye_y, s_eye_x};
            side0_reg.va  <= {s_up_z, s_up_y, s_up_x};
            side0_reg.vb  <= '0;
        end
    end

    // forward vector
    lav_norm u_norm_f (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v0_reg),
        .in_vec    (d0_reg),
        .in_side   (side0_reg),
        .out_valid (n1_v),
        .out_vec   (n1_vec),
        .out_side  (n1_side)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_f32[i] = 32'($signed(n1_vec[i]));
            n2_s32[i] = 32'($signed(n2_vec[i]));
        end
        c1_in_side     = n1_side;
        c1_in_side.va  = n1_f32;
        c1_in_side.vb  = '0;
        c2_in_side     = n2_side;
        c2_in_side.vb  = n2_s32;
    end

    // forward x up
    lav_cross u_cross_fu (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (n1_v),
        .a         (n1_f32),
        .b         (n1_side.va),
        .in_side   (c1_in_side),
        .out_valid (c1_v),
        .out_vec   (c1_vec),
        .out_side  (c1_side)
    );

    // side vector
    lav_norm u_norm_s (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c1_v),
        .in_vec    (c1_vec),
        .in_side   (c1_side),
        .out_valid (n2_v),
        .out_vec   (n2_vec),
        .out_side  (n2_side)
    );

    // true up = side x forward
    lav_cross u_cross_sf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (n2_v),
        .a         (n2_s32),
        .b         (n2_side.va),
        .in_side   (c2_in_side),
        .out_valid (c2_v),
        .out_vec   (c2_vec),
        .out_side  (c2_side)
    );

    // translation dots and matrix assembly
    lav_mat u_mat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c2_v),
        .u         (c2_vec),
        .in_side   (c2_side),
        .out_valid (mt_v),
        .out_mat   (mt_mat)
    );

    // output buffer, one entry per word
    lav_ser u_ser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (mt_v),
        .in_mat         (mt_mat),
        .load           (load),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_first_index  (m_first_index),
        .m_second_index (m_second_index),
        .m_entry_value  (entry),
        .m_last         (m_last)
    );

    assign m_entry_value = $signed(entry);

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

// Expected matrix entries and the checks against the result channel
typedef struct {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
    logic        last;
} mat_entry_t;

class matrix_scoreboard;
    mat_entry_t entry_q[$];
    int         errors;

    function new();
        errors = 0;
    endfunction

    task report(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    // drop 16 fraction bits, nearest, ties away from zero
    static function longint round_q(input longint v);
        longint unsigned mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'd1 << 15)) >> 16;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    static function longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    static function longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // unit vector; tiny vectors (length <= 1e-4) collapse to zero
    static function void unit_vec(input longint v[3], output longint o[3]);
        longint unsigned m[3], mx, sq, len, q;
        int b;
        mx = 0;
        sq = 0;
        b = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx < (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) sq += m[i] * m[i];
            if (sq <= (64'd1 << 32) / 64'd100000000) begin
                o[0] = 0; o[1] = 0; o[2] = 0;
                return;
            end
        end
        while (b < 64 && (mx >> b) != 0) b++;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            if (b > 30) m[i] >>= (b - 30);
            else m[i] <<= (30 - b);
            sq += m[i] * m[i];
        end
        len = int_sqrt(sq);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 16) + (len >> 1)) / len;
            if (q > (64'd1 << 16)) q = 64'd1 << 16;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

    static function void cross_q(input longint a[3], input longint b[3],
                                 output longint o[3]);
        o[0] = round_q(a[1] * b[2] - a[2] * b[1]);
        o[1] = round_q(a[2] * b[0] - a[0] * b[2]);
        o[2] = round_q(a[0] * b[1] - a[1] * b[0]);
    endfunction

    static function longint dot_q(input longint a[3], input longint b[3]);
        return round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
    endfunction

    // build the view matrix for one accepted word
    function void note_input(input logic signed [31:0] eye_in[3],
                             input logic signed [31:0] tgt_in[3],
                             input logic signed [31:0] up_in[3]);
        longint eye[3], dir[3], upv[3], fwd[3], fxu[3], side[3], tup[3];
        longint mat[4][4];
        mat_entry_t e;
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'(eye_in[i]);
            dir[i] = longint'(tgt_in[i]) - eye[i];
            upv[i] = longint'(up_in[i]);
        end
        unit_vec(dir, fwd);
        cross_q(fwd, upv, fxu);
        unit_vec(fxu, side);
        cross_q(side, fwd, tup);
        for (int r = 0; r < 3; r++) begin
            mat[r][0] = side[r];
            mat[r][1] = tup[r];
            mat[r][2] = -fwd[r];
            mat[r][3] = 0;
        end
        mat[3][0] = -dot_q(side, eye);
        mat[3][1] = -dot_q(tup, eye);
        mat[3][2] = dot_q(fwd, eye);
        mat[3][3] = 64'd1 << 16;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                e.row = 2'(r);
                e.col = 2'(c);
                e.value = 32'(clamp32(mat[r][c]));
                e.last = (r == 3 && c == 3);
                entry_q.push_back(e);
            end
        end
    endfunction

    task check_result(input logic [1:0] row, input logic [1:0] col,
                      input logic [31:0] value, input logic last);
        mat_entry_t e;
        if (entry_q.size() == 0) begin
            report("result word with nothing expected");
            return;
        end
        e = entry_q.pop_front();
        if (row !== e.row)
            report($sformatf("first_index %0d, expected %0d", row, e.row));
        if (col !== e.col)
            report($sformatf("second_index %0d, expected %0d", col, e.col));
        if (value !== e.value)
            report($sformatf("entry (%0d,%0d) = %h, expected %h",
                             e.row, e.col, value, e.value));
        if (last !== e.last)
            report($sformatf("last %b, expected %b", last, e.last));
    endtask
endclass

module testbench;
    import lav_pkg::*;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_eye_x, s_eye_y, s_eye_z;
    logic signed [31:0] s_target_x, s_target_y, s_target_z;
    logic signed [31:0] s_up_x, s_up_y, s_up_z;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_first_index;
    logic [1:0]         m_second_index;
    logic signed [31:0] m_entry_value;
    logic               m_last;

    matrix_scoreboard sb = new();
    bit calm;

    look_at_view_matrix uut (.*);

    // clock
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // accept monitor: both channels sampled at the edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_input('{s_eye_x, s_eye_y, s_eye_z},
                          '{s_target_x, s_target_y, s_target_z},
                          '{s_up_x, s_up_y, s_up_z});
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_first_index, m_second_index, m_entry_value, m_last);
    end

    // receiver: stall bursts unless in the calm tail
    initial begin
        m_ready = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_ready <= 1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
    end

    // one input word, held until accepted
    task send_word(input logic signed [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
        s_valid <= 1;
        s_eye_x <= ex; s_eye_y <= ey; s_eye_z <= ez;
        s_target_x <= tx; s_target_y <= ty; s_target_z <= tz;
        s_up_x <= ux; s_up_y <= uy; s_up_z <= uz;
        do @(posedge aclk); while (!s_ready);
        if (!calm && $urandom_range(0, 2) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    // coordinate of random magnitude
    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 31);
    endfunction

    task send_random();
        logic signed [31:0] e[3], t[3], u[3];
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            e[i] = rand_coord();
            t[i] = rand_coord();
            u[i] = rand_coord();
        end
        // degenerate: target on the eye
        if (kind == 0) t = e;
        // degenerate: up along the view direction
        if (kind == 1)
            for (int i = 0; i < 3; i++) begin
                t[i] = e[i] + ($signed(32'($urandom_range(0, 1 << 20))) - (1 << 19));
                u[i] = (t[i] - e[i]) <<< $urandom_range(0, 8);
            end
        // offset close to the zero-length threshold
        if (kind == 2)
            for (int i = 0; i < 3; i++) t[i] = e[i] + $signed(32'($urandom_range(0, 8))) - 4;
        send_word(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]);
    endtask

    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    initial begin
        aresetn = 0;
        calm = 0;
        s_valid = 0;
        {s_eye_x, s_eye_y, s_eye_z} = '0;
        {s_target_x, s_target_y, s_target_z} = '0;
        {s_up_x, s_up_y, s_up_z} = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed words
        send_word(0, 0, 5*ONE, 0, 0, 0, 0, ONE, 0);          // plain camera
        send_word(ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, 0, ONE, 0); // target on eye
        send_word(0, 0, 0, 0, 0, -ONE, 0, 0, ONE);           // up along view
        send_word(0, 0, 0, 3, 3, 4, 0, ONE, 0);              // just under 1e-4
        send_word(0, 0, 0, 4, 4, 4, 0, ONE, 0);              // just over
        send_word(MINV, MINV, MINV, MAXV, MAXV, MAXV, 0, ONE, 0);
        send_word(MAXV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MINV, MAXV);
        send_word(MAXV, MINV, MAXV, 0, 0, 0, MINV, MINV, MINV);
        send_word(MAXV, MAXV, MAXV, MAXV, MAXV, MINV, 0, 0, 1);
        send_word(MINV, 0, MAXV, MINV, 1, MAXV, -1, -1, -1);
        send_word(-1, -1, -1, 0, 0, 0, ONE, 0, 0);
        send_word(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(100*ONE, -50*ONE, 7*ONE, 0, ONE, 0, 0, 0, -ONE);

        for (int n = 0; n < 300; n++) begin
            // let the pipeline drain once mid-run
            if (n == 120) begin
                s_valid <= 0;
                do @(posedge aclk); while (sb.entry_q.size() != 0);
            end
            if (n == 260) calm = 1;
            send_random();
        end
        s_valid <= 0;

        while (sb.entry_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/lav_pkg.sv
hdl/lav_norm.sv
hdl/lav_cross.sv
hdl/lav_mat.sv
hdl/lav_ser.sv
hdl/look_at_view_matrix.sv
tb/sv/testbench.sv
